// ===== src/tds_pkg.sv =====
// Shared types and constants for the tridiagonal (Thomas algorithm) solver.
// No dependencies.
package tds_pkg;

   localparam int VAL_W   = 32;
   localparam int INDEX_W = 6;

   // One matrix row
   typedef struct packed {
      logic signed [VAL_W-1:0] sub_diag;
      logic signed [VAL_W-1:0] main_diag;
      logic signed [VAL_W-1:0] super_diag;
      logic signed [VAL_W-1:0] rhs_value;
      logic                    last_row;
   } req_type;

   // One solution element
   typedef struct packed {
      logic signed [VAL_W-1:0] solution_value;
      logic [INDEX_W-1:0]      solution_index;
      logic                    last_result;
      logic                    divide_error;
   } rsp_type;

   typedef enum logic [1:0] {
      MUL_AP = 2'd0,
      MUL_AQ = 2'd1,
      MUL_PX = 2'd2
   } mul_sel_type;

   typedef enum logic {
      DIV_NEG_C = 1'b0,
      DIV_NUM   = 1'b1
   } div_src_type;

   // Controller to datapath commands
   typedef struct packed {
      logic        load;
      logic        rd_en;
      logic        rd_back;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        form_row0;
      logic        form_den;
      logic        form_num;
      logic        div_start;
      div_src_type div_src;
      logic        p_hold;
      logic        wr_en;
      logic        row_inc;
      logic        row_clr;
      logic        idx_load;
      logic        idx_dec;
      logic        x_from_div;
      logic        x_from_sum;
      logic        emit;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic row_zero;
      logic row_full;
      logic idx_zero;
      logic div_done;
   } sts_type;

endpackage

// ===== src/tds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tds_divider.sv =====
// Iterative signed fixed-point divider: (num << FRAC_BITS) / den, truncating,
// saturated to 32 bits, one quotient bit per cycle. Depends on tds_pkg.
module tds_divider #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [tds_pkg::VAL_W:0]  num_arg,
   input  logic signed [tds_pkg::VAL_W:0]  den_arg,
   output logic                            done,
   output logic signed [tds_pkg::VAL_W-1:0] result
);

   localparam int DW = tds_pkg::VAL_W + 1;
   localparam int NW = DW + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);
   localparam logic [NW-1:0] POS_LIM = {{(NW-32){1'b0}}, 32'h7FFF_FFFF};
   localparam logic [NW-1:0] NEG_LIM = {{(NW-32){1'b0}}, 32'h8000_0000};

   logic              busy_ff, busy_in;
   logic              fin_ff, fin_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [NW-1:0]     numer_ff, numer_in;
   logic [NW-1:0]     quo_ff, quo_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [DW-1:0]     den_ff, den_in;
   logic              neg_ff, neg_in;
   logic signed [tds_pkg::VAL_W-1:0] result_ff, result_in;
   logic [DW:0]       trial;
   logic [DW-1:0]     num_mag, den_mag;

   assign num_mag = num_arg[DW-1] ? DW'(-num_arg) : DW'(num_arg);
   assign den_mag = den_arg[DW-1] ? DW'(-den_arg) : DW'(den_arg);
   assign trial   = {rem_ff, numer_ff[NW-1]};

   // Next state: load or zero-divisor result, shift-subtract, saturate, sign
   always_comb begin
      busy_in   = busy_ff;
      fin_in    = 1'b0;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      numer_in  = numer_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      result_in = result_ff;
      if (start) begin
         if (den_arg == '0) begin
            done_in = 1'b1;
            if (num_arg > 0) begin
               result_in = 32'sh7FFF_FFFF;
            end else if (num_arg < 0) begin
               result_in = -32'sh7FFF_FFFF - 32'sd1;
            end else begin
               result_in = '0;
            end
         end else begin
            busy_in  = 1'b1;
            cnt_in   = '0;
            numer_in = {num_mag, {FRAC_BITS{1'b0}}};
            quo_in   = '0;
            rem_in   = '0;
            den_in   = den_mag;
            neg_in   = num_arg[DW-1] ^ den_arg[DW-1];
         end
      end else if (busy_ff) begin
         numer_in = {numer_ff[NW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DW'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         if (!neg_ff) begin
            result_in = (quo_ff > POS_LIM) ? 32'sh7FFF_FFFF : $signed(quo_ff[31:0]);
         end else begin
            result_in = (quo_ff > NEG_LIM) ? (-32'sh7FFF_FFFF - 32'sd1)
                                           : $signed(-quo_ff[31:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      numer_ff  <= numer_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== src/tds_datapath.sv =====
// Datapath of the solver: row registers, p/q stores, multiplier, rounding,
// divider and result register. Depends on tds_pkg, tds_ram, tds_divider.
module tds_datapath #(
   parameter int MAX_ROWS  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  tds_pkg::req_type  req_data,
   input  tds_pkg::cmd_type  cmd,
   output tds_pkg::sts_type  sts,
   output tds_pkg::rsp_type  rsp_data
);

   localparam int IW = $clog2(MAX_ROWS);
   localparam int VW = tds_pkg::VAL_W;
   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [63:0] P_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] N_MIN = -64'sh0000_0000_8000_0000;

   logic signed [VW-1:0] a_ff, b_ff, c_ff, d_ff;
   logic signed [VW-1:0] p_rd, q_rd;
   logic signed [63:0]   prod_ff;
   logic signed [VW-1:0] rnd_ff, rnd_in;
   logic signed [VW:0]   den_ff, num_ff;
   logic signed [VW-1:0] p_hold_ff;
   logic signed [VW-1:0] x_ff;
   logic [IW-1:0]        row_ff, idx_ff;
   logic                 err_ff;
   tds_pkg::rsp_type     rsp_ff;
   logic [IW-1:0]        rd_addr;
   logic signed [63:0]   rsum, rshr;
   logic signed [VW:0]   bs_sum, div_num;
   logic signed [VW-1:0] bs_sat, div_res;
   logic                 div_done;

   // Rounded, saturated form of the registered product
   always_comb begin
      rsum = prod_ff + HALF;
      rshr = rsum >>> FRAC_BITS;
      if (rshr > P_MAX) begin
         rnd_in = 32'sh7FFF_FFFF;
      end else if (rshr < N_MIN) begin
         rnd_in = -32'sh7FFF_FFFF - 32'sd1;
      end else begin
         rnd_in = rshr[VW-1:0];
      end
   end

   // Back-substitution sum p*x + q, saturated
   always_comb begin
      bs_sum = (VW+1)'(rnd_ff) + (VW+1)'(q_rd);
      if (bs_sum[VW] != bs_sum[VW-1]) begin
         bs_sat = bs_sum[VW] ? (-32'sh7FFF_FFFF - 32'sd1) : 32'sh7FFF_FFFF;
      end else begin
         bs_sat = bs_sum[VW-1:0];
      end
   end

   assign div_num = (cmd.div_src == tds_pkg::DIV_NEG_C) ? -((VW+1)'(c_ff)) : num_ff;
   assign rd_addr = cmd.rd_back ? idx_ff : row_ff - IW'(1);

   tds_ram #(.WIDTH(VW), .DEPTH(MAX_ROWS)) u_p_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (row_ff),
      .wr_data (p_hold_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (p_rd)
   );

   tds_ram #(.WIDTH(VW), .DEPTH(MAX_ROWS)) u_q_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (row_ff),
      .wr_data (div_res),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (q_rd)
   );

   tds_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .num_arg (div_num),
      .den_arg (den_ff),
      .done    (div_done),
      .result  (div_res)
   );

   // Row counter and error flag
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         err_ff <= 1'b0;
      end else begin
         if (cmd.row_clr) begin
            row_ff <= '0;
            err_ff <= 1'b0;
         end else begin
            if (cmd.row_inc) begin
               row_ff <= row_ff + IW'(1);
            end
            if (cmd.div_start && den_ff == '0) begin
               err_ff <= 1'b1;
            end
         end
      end
   end

   // Payload, product, rounding, operand, x, index and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff <= req_data.sub_diag;
         b_ff <= req_data.main_diag;
         c_ff <= req_data.super_diag;
         d_ff <= req_data.rhs_value;
      end
      if (cmd.mul_en) begin
         unique case (cmd.mul_sel)
            tds_pkg::MUL_AP: prod_ff <= a_ff * p_rd;
            tds_pkg::MUL_AQ: prod_ff <= a_ff * q_rd;
            tds_pkg::MUL_PX: prod_ff <= p_rd * x_ff;
            default:         prod_ff <= '0;
         endcase
      end
      rnd_ff <= rnd_in;
      if (cmd.form_row0) begin
         den_ff <= (VW+1)'(b_ff);
         num_ff <= (VW+1)'(d_ff);
      end
      if (cmd.form_den) begin
         den_ff <= (VW+1)'(rnd_ff) + (VW+1)'(b_ff);
      end
      if (cmd.form_num) begin
         num_ff <= (VW+1)'(d_ff) - (VW+1)'(rnd_ff);
      end
      if (cmd.p_hold) begin
         p_hold_ff <= div_res;
      end
      if (cmd.x_from_div) begin
         x_ff <= div_res;
      end else if (cmd.x_from_sum) begin
         x_ff <= bs_sat;
      end
      if (cmd.idx_load) begin
         idx_ff <= row_ff;
      end else if (cmd.idx_dec) begin
         idx_ff <= idx_ff - IW'(1);
      end
      if (cmd.emit) begin
         rsp_ff.solution_value <= x_ff;
         rsp_ff.solution_index <= tds_pkg::INDEX_W'(idx_ff);
         rsp_ff.last_result    <= (idx_ff == '0);
         rsp_ff.divide_error   <= err_ff;
      end
   end

   assign sts.row_zero = (row_ff == '0);
   assign sts.row_full = (row_ff == IW'(MAX_ROWS - 1));
   assign sts.idx_zero = (idx_ff == '0);
   assign sts.div_done = div_done;
   assign rsp_data     = rsp_ff;

endmodule

// ===== src/tds_ctrl.sv =====
// Sequencer of the solver: forward sweep per row, then back substitution
// and result hand-off. Depends on tds_pkg.
module tds_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_last,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  tds_pkg::sts_type sts,
   output tds_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_READ, S_MUL_P, S_MUL_Q, S_FORM_D, S_FORM_N, S_ROW0,
      S_DIV_P, S_WAIT_P, S_DIV_Q, S_WAIT_Q, S_DIV_X, S_WAIT_X,
      S_EMIT, S_BS_READ, S_BS_MUL, S_BS_RND, S_BS_ADD
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Decode state into commands and next state
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      last_in   = last_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               last_in  = req_last || sts.row_full;
               state_in = sts.row_zero ? S_ROW0 : S_READ;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_MUL_P;
         end
         S_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = tds_pkg::MUL_AP;
            state_in    = S_MUL_Q;
         end
         S_MUL_Q: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = tds_pkg::MUL_AQ;
            state_in    = S_FORM_D;
         end
         S_FORM_D: begin
            cmd.form_den = 1'b1;
            state_in     = S_FORM_N;
         end
         S_FORM_N: begin
            cmd.form_num = 1'b1;
            state_in     = last_ff ? S_DIV_X : S_DIV_P;
         end
         S_ROW0: begin
            cmd.form_row0 = 1'b1;
            state_in      = last_ff ? S_DIV_X : S_DIV_P;
         end
         S_DIV_P: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = tds_pkg::DIV_NEG_C;
            state_in      = S_WAIT_P;
         end
         S_WAIT_P: begin
            if (sts.div_done) begin
               cmd.p_hold = 1'b1;
               state_in   = S_DIV_Q;
            end
         end
         S_DIV_Q: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = tds_pkg::DIV_NUM;
            state_in      = S_WAIT_Q;
         end
         S_WAIT_Q: begin
            if (sts.div_done) begin
               cmd.wr_en   = 1'b1;
               cmd.row_inc = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_DIV_X: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = tds_pkg::DIV_NUM;
            state_in      = S_WAIT_X;
         end
         S_WAIT_X: begin
            if (sts.div_done) begin
               cmd.x_from_div = 1'b1;
               cmd.idx_load   = 1'b1;
               state_in       = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               if (sts.idx_zero) begin
                  cmd.row_clr = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  cmd.idx_dec = 1'b1;
                  state_in    = S_BS_READ;
               end
            end
         end
         S_BS_READ: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_back = 1'b1;
            state_in    = S_BS_MUL;
         end
         S_BS_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = tds_pkg::MUL_PX;
            state_in    = S_BS_RND;
         end
         S_BS_RND: begin
            state_in = S_BS_ADD;
         end
         S_BS_ADD: begin
            cmd.x_from_sum = 1'b1;
            state_in       = S_EMIT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the output flag until the transaction is taken
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/tridiagonal_solver_top.sv =====
// Top level of the Thomas-algorithm tridiagonal solver.
// Depends on tds_pkg, tds_ctrl, tds_datapath.
//
//   channel | ports                         | direction | moves
//   --------+-------------------------------+-----------+---------------------
//   request | req_valid req_ready req_data  | in        | one matrix row
//   result  | rsp_valid rsp_ready rsp_data  | out       | one solution element
//
// A non-last row runs two divisions by the bit-serial divider, one quotient
// bit per cycle; row zero skips the read, multiplies and forming steps. The
// last row runs one division to its first result; each further result takes
// a read, a multiply, a rounding and an add, unstalled while rsp_ready is high.
// Reset clears the sequencer, the row count and the error flag; the p/q
// stores need no clearing. A stalled result holds the sequencer only during
// back substitution; a new row is taken while the final result still waits.
module tridiagonal_solver_top #(
   parameter int MAX_ROWS  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tds_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tds_pkg::rsp_type rsp_data
);

   tds_pkg::cmd_type cmd;
   tds_pkg::sts_type sts;

   tds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_last  (req_data.last_row),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tds_datapath #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   // A row transaction starts a busy period
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("row taken while sequencer busy");

   // Never overwrite a result that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten before transaction");

   // Final flag marks index zero exactly
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_result == (rsp_data.solution_index == '0)))
      else $error("last flag and index disagree");

   // Divider is only started from a formed denominator, never twice in a row
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !cmd.div_start)
      else $error("divider restarted while busy");

endmodule
